FILE: rtl/core/ftb_pkg.sv
`default_nettype none
package ftb_pkg;

  // Depth of the outcome window
  localparam int WINDOW_MAX = 128;
  localparam int POS_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  // Common width for length / threshold compares (register fields are 8 bits)
  localparam int EXT_W      = (CNT_W > 8) ? CNT_W : 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_OUTCOME    = 2'd0,
    MODE_CHECK      = 2'd1,
    MODE_DISCOVERED = 2'd2,
    MODE_TICK       = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_REJECTED = 2'd1,
    ST_RELEASED = 2'd2,
    ST_TRIPPED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_CONSEC = 2'd1,
    CAUSE_WINDOW = 2'd2
  } cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_PERIOD     = 3'd0,
    CFG_CONSEC_LIMIT    = 3'd1,
    CFG_WIN_THRESHOLD   = 3'd2,
    CFG_WIN_LENGTH      = 3'd3,
    CFG_HOLD_UNTIL_DISC = 3'd4,
    CFG_CONNECT_ONLY    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    mode_t mode;
    logic  failed;
    logic  is_connect_failure;
  } in_t;

  typedef struct packed {
    status_t status;
    logic    tripped;
    cause_t  trip_cause;
  } out_t;

  typedef struct packed {
    logic [15:0] hold_period;
    logic [15:0] consecutive_limit;
    logic [7:0]  window_threshold;
    logic [7:0]  window_length;
    logic        hold_until_discovered;
    logic        conn_fail_only;
  } cfg_regs_t;

  // Window memory control from the step logic
  typedef struct packed {
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic             wr_bit;
    logic             clr;
    logic [POS_W-1:0] rd_addr;
  } win_req_t;

endpackage
`default_nettype wire

FILE: rtl/core/ftb_window.sv
`default_nettype none
module ftb_window (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ftb_pkg::win_req_t req,
  output logic                   cur_bit
);

  logic                            mem [ftb_pkg::WINDOW_MAX];
  logic [ftb_pkg::WINDOW_MAX-1:0]  vld_r;
  logic [ftb_pkg::WINDOW_MAX-1:0]  vld_nxt;
  logic                            rd_mem_r;
  logic                            ovr_r;
  logic                            ovr_nxt;
  logic                            ovr_val_r;
  logic                            ovr_val_nxt;
  logic                            same_addr;

  // Entries not written since the last release read as zero.
  always_comb begin
    vld_nxt = vld_r;
    if (req.clr) begin
      vld_nxt = '0;
    end else if (req.wr_en) begin
      vld_nxt[req.wr_addr] = 1'b1;
    end
  end

  // Write-to-read bypass and invalid entries override the memory data.
  assign same_addr   = req.wr_en && (req.wr_addr == req.rd_addr);
  assign ovr_nxt     = same_addr || !vld_nxt[req.rd_addr];
  assign ovr_val_nxt = same_addr ? req.wr_bit : 1'b0;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_bit;
    end
    rd_mem_r <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      ovr_r     <= 1'b1;
      ovr_val_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      ovr_r     <= ovr_nxt;
      ovr_val_r <= ovr_val_nxt;
    end
  end

  assign cur_bit = ovr_r ? ovr_val_r : rd_mem_r;

endmodule
`default_nettype wire

FILE: rtl/core/ftb_core.sv
`default_nettype none
module ftb_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire ftb_pkg::in_t       item,
  input  wire ftb_pkg::cfg_regs_t cfg,
  input  wire logic               cur_bit,
  output ftb_pkg::win_req_t       win_req,
  output ftb_pkg::out_t           res
);

  logic [15:0]                cnt_r, cnt_nxt, cnt_sat;
  logic [ftb_pkg::POS_W-1:0]  pos_r, pos_nxt, pos_wrap;
  logic [ftb_pkg::CNT_W-1:0]  ones_r, ones_nxt, ones_inc;
  logic                       trip_r, trip_nxt;
  logic                       seen_r, seen_nxt;
  logic [15:0]                hold_r, hold_nxt;
  logic [ftb_pkg::EXT_W-1:0]  len_ext, eff_len, pos_inc;
  logic                       ignored;
  logic                       fire_c, fire_w;
  logic                       wr_en, clr;
  ftb_pkg::status_t           status;
  ftb_pkg::cause_t            cause;

  assign cnt_sat  = (cnt_r != 16'hFFFF) ? cnt_r + 16'd1 : cnt_r;
  assign ones_inc = ones_r + ftb_pkg::CNT_W'(1);

  // Window length clamped to 1..WINDOW_MAX
  assign len_ext = ftb_pkg::EXT_W'(cfg.window_length);
  always_comb begin
    if (len_ext == '0) begin
      eff_len = ftb_pkg::EXT_W'(1);
    end else if (len_ext > ftb_pkg::EXT_W'(ftb_pkg::WINDOW_MAX)) begin
      eff_len = ftb_pkg::EXT_W'(ftb_pkg::WINDOW_MAX);
    end else begin
      eff_len = len_ext;
    end
  end
  assign pos_inc  = ftb_pkg::EXT_W'(pos_r) + ftb_pkg::EXT_W'(1);
  assign pos_wrap = (pos_inc >= eff_len) ? '0 : pos_inc[ftb_pkg::POS_W-1:0];

  assign ignored = item.failed && cfg.conn_fail_only && !item.is_connect_failure;

  always_comb begin
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    ones_nxt = ones_r;
    trip_nxt = trip_r;
    seen_nxt = seen_r;
    hold_nxt = hold_r;
    fire_c   = 1'b0;
    fire_w   = 1'b0;
    wr_en    = 1'b0;
    clr      = 1'b0;
    status   = ftb_pkg::ST_NONE;
    cause    = ftb_pkg::CAUSE_NONE;
    if (step) begin
      case (item.mode)
        ftb_pkg::MODE_OUTCOME: begin
          if (cfg.hold_period != '0 && !ignored) begin
            if (cfg.consecutive_limit != '0) begin
              if (!item.failed) begin
                cnt_nxt = '0;
              end else begin
                cnt_nxt = cnt_sat;
                fire_c  = (cnt_sat >= cfg.consecutive_limit);
              end
            end
            if (cfg.window_threshold != '0) begin
              if (cur_bit != item.failed) begin
                wr_en = 1'b1;
                if (item.failed) begin
                  ones_nxt = ones_inc;
                  fire_w   = (ftb_pkg::EXT_W'(ones_inc) >=
                              ftb_pkg::EXT_W'(cfg.window_threshold));
                end else if (ones_r != '0) begin
                  ones_nxt = ones_r - ftb_pkg::CNT_W'(1);
                end
              end
              pos_nxt = pos_wrap;
            end
            if (fire_c || fire_w) begin
              trip_nxt = 1'b1;
              status   = ftb_pkg::ST_TRIPPED;
              cause    = fire_w ? ftb_pkg::CAUSE_WINDOW : ftb_pkg::CAUSE_CONSEC;
            end
            if (fire_c || fire_w || trip_r) begin
              seen_nxt = 1'b0;
              hold_nxt = cfg.hold_period;
            end
          end
        end
        ftb_pkg::MODE_CHECK: begin
          if (cfg.hold_period != '0 && trip_r) begin
            if (hold_r == '0 && (!cfg.hold_until_discovered || seen_r)) begin
              cnt_nxt  = '0;
              pos_nxt  = '0;
              ones_nxt = '0;
              clr      = 1'b1;
              trip_nxt = 1'b0;
              status   = ftb_pkg::ST_RELEASED;
            end else begin
              status   = ftb_pkg::ST_REJECTED;
            end
          end
        end
        ftb_pkg::MODE_DISCOVERED: begin
          seen_nxt = 1'b1;
        end
        ftb_pkg::MODE_TICK: begin
          if (hold_r != '0) begin
            hold_nxt = hold_r - 16'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pos_r  <= '0;
      ones_r <= '0;
      trip_r <= 1'b0;
      seen_r <= 1'b0;
      hold_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      pos_r  <= pos_nxt;
      ones_r <= ones_nxt;
      trip_r <= trip_nxt;
      seen_r <= seen_nxt;
      hold_r <= hold_nxt;
    end
  end

  // Read address follows the next position so the bit is ready for the next item
  assign win_req.wr_en   = wr_en;
  assign win_req.wr_addr = pos_r;
  assign win_req.wr_bit  = item.failed;
  assign win_req.clr     = clr;
  assign win_req.rd_addr = pos_nxt;

  assign res.status     = status;
  assign res.tripped    = trip_nxt;
  assign res.trip_cause = cause;

endmodule
`default_nettype wire

FILE: rtl/core/failure_throttle_breaker_top.sv
// Pipeline: the input register (stage 1), then the result register.
// One item per cycle while out_stall is low; every item yields exactly one result.
// The window bit for the next item is read from the window RAM as the current item steps.
// Reset (rst_n low, synchronous): pipeline empty, breaker closed, counters and window
// cleared, registers at hold_period 0 (breaker off) and window_length 1.
`default_nettype none
module failure_throttle_breaker_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // item input
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire ftb_pkg::in_t                       in_data,
  // result output
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output ftb_pkg::out_t                           out_data,
  // register writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ftb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ftb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ftb_pkg::cfg_regs_t cfg_r;
  ftb_pkg::in_t       s1_data_r;
  logic               s1_valid_r, s1_valid_nxt;
  ftb_pkg::out_t      out_data_r;
  logic               out_valid_r, out_valid_nxt;
  logic               in_xfer;
  logic               advance;
  logic               cur_bit;
  ftb_pkg::win_req_t  win_req;
  ftb_pkg::out_t      res;

  // ---------------------------------------------------------------------------
  // Register port: always ready, writes are registered.
  // Indexes beyond the last register are accepted and dropped.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_period           <= '0;
      cfg_r.consecutive_limit     <= '0;
      cfg_r.window_threshold      <= '0;
      cfg_r.window_length         <= 8'd1;
      cfg_r.hold_until_discovered <= 1'b0;
      cfg_r.conn_fail_only        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ftb_pkg::CFG_HOLD_PERIOD:     cfg_r.hold_period           <= cfg_data[15:0];
        ftb_pkg::CFG_CONSEC_LIMIT:    cfg_r.consecutive_limit     <= cfg_data[15:0];
        ftb_pkg::CFG_WIN_THRESHOLD:   cfg_r.window_threshold      <= cfg_data[7:0];
        ftb_pkg::CFG_WIN_LENGTH:      cfg_r.window_length         <= cfg_data[7:0];
        ftb_pkg::CFG_HOLD_UNTIL_DISC: cfg_r.hold_until_discovered <= cfg_data[0];
        ftb_pkg::CFG_CONNECT_ONLY:    cfg_r.conn_fail_only        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control.
  // Stage 1 holds the accepted item; it is evaluated and its state update
  // committed at the same edge that loads the result register. The result
  // register keeps a finished result while the next item waits in stage 1,
  // so input transfers continue every cycle as long as the output drains.
  // ---------------------------------------------------------------------------
  assign advance      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = s1_valid_r && !advance;
  assign in_xfer      = in_valid && !in_stall;
  assign s1_valid_nxt = in_xfer || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Breaker state and step logic; window bits in a RAM with per-entry
  // valid flags so a release clears the whole window at once.
  // ---------------------------------------------------------------------------
  ftb_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (s1_data_r),
    .cfg     (cfg_r),
    .cur_bit (cur_bit),
    .win_req (win_req),
    .res     (res)
  );

  ftb_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (win_req),
    .cur_bit (cur_bit)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // a release always leaves the breaker closed
  a_release_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ftb_pkg::ST_RELEASED) |-> !out_data.tripped)
    else $error("release result with breaker still tripped");

  // a trip result always reports an open breaker and a cause
  a_trip_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ftb_pkg::ST_TRIPPED) |->
      out_data.tripped && (out_data.trip_cause != ftb_pkg::CAUSE_NONE))
    else $error("trip result without open breaker or cause");

  // cause only appears on trip results
  a_cause_only_on_trip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.trip_cause != ftb_pkg::CAUSE_NONE) |->
      (out_data.status == ftb_pkg::ST_TRIPPED))
    else $error("trip cause on a non-trip result");

  // an item that cannot advance stays in stage 1
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_data_r))
    else $error("stalled item lost from stage 1");

endmodule
`default_nettype wire

FILE: tb/failure_throttle_breaker_top_tb.sv
`timescale 1ns / 100ps
module failure_throttle_breaker_top_tb;

  // Watchdog: cycles in a row with no transfer on any channel
  localparam int STALL_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  ftb_pkg::in_t in_data = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  ftb_pkg::out_t out_data;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ftb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ftb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  failure_throttle_breaker_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Breaker shadow: register copy plus the breaker state, updated per transfer
  // ---------------------------------------------------------------------------
  ftb_pkg::cfg_regs_t regs_now;
  logic [15:0] fail_run;
  bit          win_bits [ftb_pkg::WINDOW_MAX];
  int          win_pos;
  int          win_ones;
  bit          brk_tripped;
  bit          disc_seen;
  logic [15:0] hold_left;

  ftb_pkg::out_t pending_results[$];
  int   taken_items = 0;
  int   taken_cfgs = 0;
  int   err_count = 0;
  bit   calm = 1'b0;   // when set, neither side idles

  initial begin
    regs_now = '0;
    regs_now.window_length = 8'd1;
    fail_run = '0;
    win_pos = 0;
    win_ones = 0;
    brk_tripped = 1'b0;
    disc_seen = 1'b0;
    hold_left = '0;
    foreach (win_bits[i]) win_bits[i] = 1'b0;
  end

  function automatic void clear_window();
    fail_run = '0;
    foreach (win_bits[i]) win_bits[i] = 1'b0;
    win_pos = 0;
    win_ones = 0;
  endfunction

  // Next breaker state and the result word for one item
  function automatic ftb_pkg::out_t breaker_step(ftb_pkg::in_t it);
    ftb_pkg::out_t   r;
    bit              fired;
    ftb_pkg::cause_t cz;
    int              p;
    int              eff;
    r.status = ftb_pkg::ST_NONE;
    r.trip_cause = ftb_pkg::CAUSE_NONE;
    fired = 1'b0;
    cz = ftb_pkg::CAUSE_NONE;
    case (it.mode)
      ftb_pkg::MODE_OUTCOME: begin
        // zero hold period: breaker off, outcome has no effect
        if (regs_now.hold_period != 0 &&
            !(it.failed && regs_now.conn_fail_only && !it.is_connect_failure)) begin
          if (regs_now.consecutive_limit != 0) begin
            if (!it.failed) begin
              fail_run = '0;
            end else begin
              if (fail_run != 16'hFFFF) fail_run++;
              if (fail_run >= regs_now.consecutive_limit) begin
                fired = 1'b1;
                cz = ftb_pkg::CAUSE_CONSEC;
              end
            end
          end
          if (regs_now.window_threshold != 0) begin
            p = (win_pos >= ftb_pkg::WINDOW_MAX) ? 0 : win_pos;
            if (win_bits[p] != it.failed) begin
              win_bits[p] = it.failed;
              if (it.failed) win_ones++;
              else if (win_ones > 0) win_ones--;
              // window rule overrides the consecutive cause
              if (it.failed && win_ones >= regs_now.window_threshold) begin
                fired = 1'b1;
                cz = ftb_pkg::CAUSE_WINDOW;
              end
            end
            eff = (regs_now.window_length == 0) ? 1 :
                  (regs_now.window_length > ftb_pkg::WINDOW_MAX) ? ftb_pkg::WINDOW_MAX :
                  int'(regs_now.window_length);
            p++;
            if (p >= eff) p = 0;
            win_pos = p;
          end
          if (fired) brk_tripped = 1'b1;
          // any counted outcome while open restarts the hold
          if (brk_tripped) begin
            disc_seen = 1'b0;
            hold_left = regs_now.hold_period;
          end
          if (fired) begin
            r.status = ftb_pkg::ST_TRIPPED;
            r.trip_cause = cz;
          end
        end
      end
      ftb_pkg::MODE_CHECK: begin
        if (regs_now.hold_period != 0 && brk_tripped) begin
          if (hold_left == 0 && (!regs_now.hold_until_discovered || disc_seen)) begin
            clear_window();
            brk_tripped = 1'b0;
            r.status = ftb_pkg::ST_RELEASED;
          end else begin
            r.status = ftb_pkg::ST_REJECTED;
          end
        end
      end
      ftb_pkg::MODE_DISCOVERED: disc_seen = 1'b1;
      default: if (hold_left != 0) hold_left--;
    endcase
    r.tripped = brk_tripped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer monitor: predicts on each input transfer, tracks register writes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        pending_results.insert(pending_results.size(), breaker_step(in_data));
        taken_items++;
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        case (ftb_pkg::cfg_idx_t'(cfg_index))
          ftb_pkg::CFG_HOLD_PERIOD:     regs_now.hold_period = cfg_data;
          ftb_pkg::CFG_CONSEC_LIMIT:    regs_now.consecutive_limit = cfg_data;
          ftb_pkg::CFG_WIN_THRESHOLD:   regs_now.window_threshold = cfg_data[7:0];
          ftb_pkg::CFG_WIN_LENGTH:      regs_now.window_length = cfg_data[7:0];
          ftb_pkg::CFG_HOLD_UNTIL_DISC: regs_now.hold_until_discovered = cfg_data[0];
          ftb_pkg::CFG_CONNECT_ONLY:    regs_now.conn_fail_only = cfg_data[0];
          default: ;
        endcase
        taken_cfgs++;
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
    err_count++;
  endtask

  // Result checker: in-order compare against the oldest expectation
  always @(posedge clk) begin
    ftb_pkg::out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", out_data.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.tripped !== want.tripped)
          report_mismatch("tripped", out_data.tripped, want.tripped);
        if (out_data.trip_cause !== want.trip_cause)
          report_mismatch("trip_cause", out_data.trip_cause, want.trip_cause);
      end
    end
  end

  // Watchdog on transfer progress
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0) || (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("failure_throttle_breaker_top_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver back-pressure, about 14 percent of cycles
  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 14);
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and returns just after a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(ftb_pkg::in_t it);
    int n;
    if (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    n = taken_items;
    in_valid <= 1'b1;
    in_data <= it;
    do @(negedge clk); while (taken_items == n);
  endtask

  // Drop valid and wait out every pending result plus the pipeline depth
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(ftb_pkg::cfg_idx_t idx, logic [15:0] v);
    int n;
    n = taken_cfgs;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(negedge clk); while (taken_cfgs == n);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(logic [15:0] hold, logic [15:0] consec, logic [7:0] thr,
                          logic [7:0] len, logic hud, logic cfo);
    cfg_write(ftb_pkg::CFG_HOLD_PERIOD, hold);
    cfg_write(ftb_pkg::CFG_CONSEC_LIMIT, consec);
    cfg_write(ftb_pkg::CFG_WIN_THRESHOLD, {8'h00, thr});
    cfg_write(ftb_pkg::CFG_WIN_LENGTH, {8'h00, len});
    cfg_write(ftb_pkg::CFG_HOLD_UNTIL_DISC, {15'd0, hud});
    cfg_write(ftb_pkg::CFG_CONNECT_ONLY, {15'd0, cfo});
  endtask

  function automatic ftb_pkg::in_t item_of(ftb_pkg::mode_t m, logic f, logic c);
    ftb_pkg::in_t it;
    it.mode = m;
    it.failed = f;
    it.is_connect_failure = c;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: hold period zero, so outcomes and checks do nothing
  task automatic test_breaker_disabled();
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b1));
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b0));
    send_item(item_of(ftb_pkg::MODE_CHECK, 1'b0, 1'b0));
    send_item(item_of(ftb_pkg::MODE_DISCOVERED, 1'b0, 1'b0));
    send_item(item_of(ftb_pkg::MODE_TICK, 1'b1, 1'b1));
    drain_results();
  endtask

  // Consecutive rule trips, check rejects until the hold has ticked away
  task automatic test_consecutive_trip();
    set_regs(16'd2, 16'd3, 8'd0, 8'd1, 1'b0, 1'b0);
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b0));
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b0, 1'b0));
    repeat (3) send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b0));
    send_item(item_of(ftb_pkg::MODE_CHECK, 1'b0, 1'b0));
    repeat (2) send_item(item_of(ftb_pkg::MODE_TICK, 1'b0, 1'b0));
    send_item(item_of(ftb_pkg::MODE_CHECK, 1'b0, 1'b0));
    drain_results();
  endtask

  // Window rate trip, then both rules at once, then an outcome while open
  task automatic test_window_trip();
    set_regs(16'd1, 16'd2, 8'd2, 8'd4, 1'b0, 1'b0);
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b1));
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b0, 1'b0));
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b0));
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b0));
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b0, 1'b1));
    send_item(item_of(ftb_pkg::MODE_TICK, 1'b0, 1'b0));
    send_item(item_of(ftb_pkg::MODE_CHECK, 1'b0, 1'b0));
    drain_results();
  endtask

  // Connect-only filtering and release gated on a discovery
  task automatic test_discovery_gate();
    set_regs(16'd1, 16'd1, 8'd0, 8'd1, 1'b1, 1'b1);
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b0));
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b1));
    send_item(item_of(ftb_pkg::MODE_TICK, 1'b0, 1'b0));
    send_item(item_of(ftb_pkg::MODE_CHECK, 1'b0, 1'b0));
    send_item(item_of(ftb_pkg::MODE_DISCOVERED, 1'b1, 1'b1));
    send_item(item_of(ftb_pkg::MODE_CHECK, 1'b0, 1'b0));
    drain_results();
  endtask

  // Full-scale registers; window length zero and above the window depth
  task automatic test_extreme_regs();
    set_regs(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 1'b1, 1'b0);
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b0));
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b0, 1'b0));
    drain_results();
    cfg_write(ftb_pkg::CFG_WIN_LENGTH, 16'h00FF);
    cfg_write(ftb_pkg::CFG_WIN_THRESHOLD, 16'h0080);
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b1));
    send_item(item_of(ftb_pkg::MODE_CHECK, 1'b0, 1'b0));
    drain_results();
  endtask

  // Long failure run with no idling: trips at the limit and keeps firing
  task automatic test_long_fail_run();
    set_regs(16'd1, 16'd24, 8'd0, 8'd1, 1'b0, 1'b0);
    calm = 1'b1;
    repeat (30) send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b1, 1'b0));
    send_item(item_of(ftb_pkg::MODE_OUTCOME, 1'b0, 1'b0));
    send_item(item_of(ftb_pkg::MODE_TICK, 1'b0, 1'b0));
    send_item(item_of(ftb_pkg::MODE_CHECK, 1'b0, 1'b0));
    drain_results();
    calm = 1'b0;
  endtask

  function automatic ftb_pkg::in_t rand_item();
    ftb_pkg::in_t it;
    int  r;
    r = $urandom_range(99);
    if (r < 50) it.mode = ftb_pkg::MODE_OUTCOME;
    else if (r < 68) it.mode = ftb_pkg::MODE_CHECK;
    else if (r < 78) it.mode = ftb_pkg::MODE_DISCOVERED;
    else it.mode = ftb_pkg::MODE_TICK;
    it.failed = ($urandom_range(99) < 60);
    it.is_connect_failure = 1'($urandom_range(1));
    return it;
  endfunction

  // Random register set per phase, short holds and windows most of the time
  task automatic randomize_regs();
    logic [15:0] hold;
    logic [15:0] consec;
    logic [7:0]  thr;
    logic [7:0]  len;
    int r;
    r = $urandom_range(99);
    hold = (r < 10) ? 16'd0 : (r < 88) ? 16'($urandom_range(5, 1)) : 16'hFFFF;
    r = $urandom_range(99);
    consec = (r < 20) ? 16'd0 : (r < 92) ? 16'($urandom_range(6, 1)) : 16'hFFFF;
    r = $urandom_range(99);
    thr = (r < 20) ? 8'd0 : (r < 85) ? 8'($urandom_range(8, 1)) :
          (r < 93) ? 8'd128 : 8'hFF;
    r = $urandom_range(99);
    len = (r < 10) ? 8'd0 : (r < 80) ? 8'($urandom_range(12, 1)) :
          (r < 90) ? 8'd128 : 8'($urandom_range(255, 129));
    set_regs(hold, consec, thr, len, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Random traffic over several register settings; one phase has no idling,
  // and one phase pauses mid-stream until every result is back
  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      randomize_regs();
      calm = (ph == 2);
      for (int k = 0; k < 140; k++) begin
        if (ph == 3 && k == 70) drain_results();
        send_item(rand_item());
      end
      drain_results();
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_breaker_disabled();
    test_consecutive_trip();
    test_window_trip();
    test_discovery_gate();
    test_extreme_regs();
    test_long_fail_run();
    test_random_traffic();

    // drain_results already waited out the pipeline
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("failure_throttle_breaker_top_tb: done, clean");
    end else begin
      $display("failure_throttle_breaker_top_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ftb_pkg.sv
rtl/core/ftb_window.sv
rtl/core/ftb_core.sv
rtl/core/failure_throttle_breaker_top.sv
tb/failure_throttle_breaker_top_tb.sv
